FILE: sv/kahn_cycle_detect_defines.svh
// ----------------------------------------------------------------------------
// kahn_cycle_detect assertion macros
// concurrent checks clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef KAHN_CYCLE_DETECT_DEFINES_SVH
`define KAHN_CYCLE_DETECT_DEFINES_SVH

`ifndef SYNTH
`define KCD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define KCD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KCD_ASSERT_IMP(lbl, ante, cons, msg)
`define KCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg
// shared constants and control/status bundles for the cycle detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcd_pkg;

   localparam int VCOUNT_W   = 7;
   localparam int VID_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_VERTEX_COUNT = 3'd0;
   localparam logic [VCOUNT_W-1:0]   VCOUNT_RESET     = 7'd64;

   typedef struct packed {
      logic cap;
      logic set_drop;
      logic add_rd;
      logic add_wr;
      logic row_set_nr;
      logic row_set_zero;
      logic row_inc;
      logic row_rd;
      logic col_clr;
      logic col_inc;
      logic deg_rd_col;
      logic deg_dec;
      logic enq_zero;
      logic enq_one;
      logic q_reset;
      logic pop;
      logic adj_rd_q;
      logic result_ld;
      logic clr_wr;
   } ctl_type;

   typedef struct packed {
      logic req_eval;
      logic in_range;
      logic row_end;
      logic clr_last;
      logic col_end_rows;
      logic col_end_n;
      logic col_bit;
      logic q_empty;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: sv/kcd_if.sv
// ----------------------------------------------------------------------------
// kcd channel interfaces
// valid/ready channels for edge commands and evaluation results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kcd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [kcd_pkg::VID_W-1:0] edge_from;
   logic [kcd_pkg::VID_W-1:0] edge_to;

   modport source(output valid, cmd, edge_from, edge_to, input ready);
   modport sink(input valid, cmd, edge_from, edge_to, output ready);
endinterface

interface kcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         has_cycle;
   logic [kcd_pkg::VCOUNT_W-1:0] visited_count;
   logic                         dropped_edge;

   modport source(output valid, has_cycle, visited_count, dropped_edge, input ready);
   modport sink(input valid, has_cycle, visited_count, dropped_edge, output ready);
endinterface

FILE: sv/kcd_ctrl.sv
// ----------------------------------------------------------------------------
// kcd_ctrl
// sequencer for edge loads, the topological walk and the clearing sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kcd_pkg::sts_type sts,
   output kcd_pkg::ctl_type ctl
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADD_RD    = 4'd1;
   localparam logic [3:0] S_ADD_WR    = 4'd2;
   localparam logic [3:0] S_TRIM_ROW  = 4'd3;
   localparam logic [3:0] S_TRIM_COL  = 4'd4;
   localparam logic [3:0] S_TRIM_DEC  = 4'd5;
   localparam logic [3:0] S_SWEEP     = 4'd6;
   localparam logic [3:0] S_SWEEP_CHK = 4'd7;
   localparam logic [3:0] S_POP       = 4'd8;
   localparam logic [3:0] S_POP_ROW   = 4'd9;
   localparam logic [3:0] S_SCAN      = 4'd10;
   localparam logic [3:0] S_SCAN_DEC  = 4'd11;
   localparam logic [3:0] S_DONE      = 4'd12;
   localparam logic [3:0] S_CLEAR     = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.cap = 1'b1;
               if (sts.req_eval) begin
                  ctl.row_set_nr = 1'b1;
                  state_in       = S_TRIM_ROW;
               end else begin
                  state_in = S_ADD_RD;
               end
            end
         end
         S_ADD_RD: begin
            if (!sts.in_range) begin
               ctl.set_drop = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctl.add_rd = 1'b1;
               state_in   = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            ctl.add_wr = 1'b1;
            state_in   = S_IDLE;
         end
         // drop edges of rows beyond the current count
         S_TRIM_ROW: begin
            ctl.col_clr = 1'b1;
            if (sts.row_end) begin
               ctl.q_reset = 1'b1;
               state_in    = S_SWEEP;
            end else begin
               ctl.row_rd = 1'b1;
               state_in   = S_TRIM_COL;
            end
         end
         S_TRIM_COL: begin
            if (sts.col_end_rows) begin
               ctl.row_inc = 1'b1;
               state_in    = S_TRIM_ROW;
            end else if (sts.col_bit) begin
               ctl.deg_rd_col = 1'b1;
               state_in       = S_TRIM_DEC;
            end else begin
               ctl.col_inc = 1'b1;
            end
         end
         S_TRIM_DEC: begin
            ctl.deg_dec = 1'b1;
            ctl.col_inc = 1'b1;
            state_in    = S_TRIM_COL;
         end
         // seed the queue with sources
         S_SWEEP: begin
            if (sts.col_end_n) begin
               state_in = S_POP;
            end else begin
               ctl.deg_rd_col = 1'b1;
               state_in       = S_SWEEP_CHK;
            end
         end
         S_SWEEP_CHK: begin
            ctl.enq_zero = 1'b1;
            ctl.col_inc  = 1'b1;
            state_in     = S_SWEEP;
         end
         S_POP: begin
            if (sts.q_empty) begin
               state_in = S_DONE;
            end else begin
               ctl.pop  = 1'b1;
               state_in = S_POP_ROW;
            end
         end
         S_POP_ROW: begin
            ctl.adj_rd_q = 1'b1;
            ctl.col_clr  = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            if (sts.col_end_n) begin
               state_in = S_POP;
            end else if (sts.col_bit) begin
               ctl.deg_rd_col = 1'b1;
               state_in       = S_SCAN_DEC;
            end else begin
               ctl.col_inc = 1'b1;
            end
         end
         S_SCAN_DEC: begin
            ctl.deg_dec = 1'b1;
            ctl.enq_one = 1'b1;
            ctl.col_inc = 1'b1;
            state_in    = S_SCAN;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               ctl.result_ld    = 1'b1;
               ctl.row_set_zero = 1'b1;
               state_in         = S_CLEAR;
            end
         end
         S_CLEAR: begin
            ctl.clr_wr  = 1'b1;
            ctl.row_inc = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/kcd_dpath.sv
// ----------------------------------------------------------------------------
// kcd_dpath
// adjacency, in-degree and queue memories with the walk counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcd_dpath #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kcd_pkg::ctl_type                    ctl,
   output kcd_pkg::sts_type                    sts,
   input  logic [kcd_pkg::VCOUNT_W-1:0]        vertex_count,
   input  logic                                req_cmd,
   input  logic [kcd_pkg::VID_W-1:0]           req_edge_from,
   input  logic [kcd_pkg::VID_W-1:0]           req_edge_to,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_has_cycle,
   output logic [kcd_pkg::VCOUNT_W-1:0]        rsp_visited_count,
   output logic                                rsp_dropped_edge
);

   // only vertices an edge can name get rows
   localparam int ROWS = (MAX_VERTICES < (1 << kcd_pkg::VID_W)) ?
                         MAX_VERTICES : (1 << kcd_pkg::VID_W);
   localparam int RW   = $clog2(ROWS);
   localparam int DW   = $clog2(ROWS + 1);
   localparam int CW   = kcd_pkg::VCOUNT_W;
   localparam logic [RW:0] ROWS_C = (RW+1)'(ROWS);

   logic [ROWS-1:0] adj_mem [ROWS];
   logic [DW-1:0]   deg_mem [ROWS];
   logic [RW-1:0]   q_mem   [ROWS];

   logic [ROWS-1:0] adj_rd_ff;
   logic [DW-1:0]   deg_rd_ff;
   logic [RW-1:0]   q_rd_ff;

   logic [kcd_pkg::VID_W-1:0] from_ff;
   logic [kcd_pkg::VID_W-1:0] to_ff;
   logic [RW:0]     row_ff;
   logic [RW:0]     col_ff;
   logic [RW:0]     head_ff;
   logic [RW:0]     tail_ff;
   logic [CW-1:0]   visits_ff;
   logic            drop_ff;
   logic            rsp_valid_ff;
   logic            has_cycle_ff;
   logic [CW-1:0]   visited_ff;
   logic            dropped_ff;

   logic [CW-1:0]   eff;
   logic [CW-1:0]   nr;
   logic [CW-1:0]   total;
   logic [RW-1:0]   from_idx;
   logic [RW-1:0]   to_idx;
   logic [RW-1:0]   row_idx;
   logic [RW-1:0]   col_idx;
   logic            bit_set;
   logic            enq;

   logic            adj_re;
   logic [RW-1:0]   adj_ra;
   logic            adj_we;
   logic [RW-1:0]   adj_wa;
   logic [ROWS-1:0] adj_wd;
   logic            deg_re;
   logic [RW-1:0]   deg_ra;
   logic            deg_we;
   logic [RW-1:0]   deg_wa;
   logic [DW-1:0]   deg_wd;

   // zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (vertex_count == '0) begin
         eff = CW'(1);
      end else if (32'(vertex_count) > MAX_VERTICES) begin
         eff = CW'(MAX_VERTICES);
      end else begin
         eff = vertex_count;
      end
      nr = (32'(eff) > ROWS) ? CW'(ROWS) : eff;
   end

   assign from_idx = from_ff[RW-1:0];
   assign to_idx   = to_ff[RW-1:0];
   assign row_idx  = row_ff[RW-1:0];
   assign col_idx  = col_ff[RW-1:0];
   assign bit_set  = adj_rd_ff[to_idx];
   // vertices without a row never have edges, so all of them are visited
   assign total    = visits_ff + (eff - nr);
   assign enq      = (ctl.enq_zero && deg_rd_ff == '0) ||
                     (ctl.enq_one && deg_rd_ff == DW'(1));

   always_comb begin
      sts.req_eval     = (req_cmd == kcd_pkg::CMD_EVAL);
      sts.in_range     = ({1'b0, from_ff} < eff) && ({1'b0, to_ff} < eff);
      sts.row_end      = (row_ff == ROWS_C);
      sts.clr_last     = (row_ff == ROWS_C - 1'b1);
      sts.col_end_rows = (col_ff == ROWS_C);
      sts.col_end_n    = (CW'(col_ff) == nr);
      sts.col_bit      = adj_rd_ff[col_idx];
      sts.q_empty      = (head_ff == tail_ff);
      sts.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      adj_re = ctl.add_rd || ctl.row_rd || ctl.adj_rd_q;
      adj_ra = ctl.add_rd ? from_idx : (ctl.row_rd ? row_idx : q_rd_ff);
      adj_we = ctl.clr_wr || (ctl.add_wr && !bit_set);
      adj_wa = ctl.clr_wr ? row_idx : from_idx;
      adj_wd = ctl.clr_wr ? '0 : (adj_rd_ff | (ROWS'(1) << to_idx));
      deg_re = ctl.add_rd || ctl.deg_rd_col;
      deg_ra = ctl.add_rd ? to_idx : col_idx;
      deg_we = 1'b0;
      deg_wa = row_idx;
      deg_wd = '0;
      if (ctl.clr_wr) begin
         deg_we = 1'b1;
      end else if (ctl.add_wr && !bit_set) begin
         deg_we = 1'b1;
         deg_wa = to_idx;
         deg_wd = deg_rd_ff + 1'b1;
      end else if (ctl.deg_dec && deg_rd_ff != '0) begin
         deg_we = 1'b1;
         deg_wa = col_idx;
         deg_wd = deg_rd_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      if (adj_re) begin
         adj_rd_ff <= adj_mem[adj_ra];
      end
      if (deg_we) begin
         deg_mem[deg_wa] <= deg_wd;
      end
      if (deg_re) begin
         deg_rd_ff <= deg_mem[deg_ra];
      end
      if (enq) begin
         q_mem[tail_ff[RW-1:0]] <= col_idx;
      end
      if (ctl.pop) begin
         q_rd_ff <= q_mem[head_ff[RW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         from_ff <= req_edge_from;
         to_ff   <= req_edge_to;
      end
      if (ctl.result_ld) begin
         has_cycle_ff <= (total != eff);
         visited_ff   <= total;
         dropped_ff   <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         visits_ff    <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.row_set_nr) begin
            row_ff <= nr[RW:0];
         end else if (ctl.row_set_zero) begin
            row_ff <= '0;
         end else if (ctl.row_inc) begin
            row_ff <= row_ff + 1'b1;
         end
         if (ctl.col_clr) begin
            col_ff <= '0;
         end else if (ctl.col_inc) begin
            col_ff <= col_ff + 1'b1;
         end
         if (ctl.q_reset) begin
            head_ff   <= '0;
            tail_ff   <= '0;
            visits_ff <= '0;
         end else begin
            if (ctl.pop) begin
               head_ff   <= head_ff + 1'b1;
               visits_ff <= visits_ff + 1'b1;
            end
            if (enq) begin
               tail_ff <= tail_ff + 1'b1;
            end
         end
         if (ctl.set_drop) begin
            drop_ff <= 1'b1;
         end else if (ctl.result_ld) begin
            drop_ff <= 1'b0;
         end
         if (ctl.result_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_cycle     = has_cycle_ff;
   assign rsp_visited_count = visited_ff;
   assign rsp_dropped_edge  = dropped_ff;

endmodule

FILE: sv/kahn_cycle_detect.sv
// ----------------------------------------------------------------------------
// kahn_cycle_detect
// directed-graph cycle test by topological sort over an adjacency matrix
// ----------------------------------------------------------------------------
//   channel   dir   transfer
//   req_ch    in    cmd, edge_from, edge_to
//   rsp_ch    out   has_cycle, visited_count, dropped_edge (evaluate only)
//   csr_*     in    apb write/read of vertex_count at byte address 0
//
// an edge load reads the source row and target in-degree and writes both unless
// the edge is already present; an edge out of range is dropped instead
// an evaluation removes rows above the count from in-degrees, seeds the queue
// with the sources, then pops each vertex and lowers its successors' in-degrees;
// a clearing sweep over all min(max,64) rows ends it; reset runs the same sweep
// a waiting result holds the next evaluation at its end, edge loads go on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kahn_cycle_detect_defines.svh"

module kahn_cycle_detect #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   kcd_req_if.sink                              req_ch,
   kcd_rsp_if.source                            rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [kcd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [kcd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [kcd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   kcd_pkg::ctl_type ctl;
   kcd_pkg::sts_type sts;

   logic [kcd_pkg::VCOUNT_W-1:0] vcount_ff;
   logic                         eval_xfer;
   logic                         rsp_stall;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= kcd_pkg::VCOUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == kcd_pkg::REG_VERTEX_COUNT) begin
         vcount_ff <= csr_pwdata[kcd_pkg::VCOUNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == kcd_pkg::REG_VERTEX_COUNT) ?
                       kcd_pkg::CSR_DATA_W'(vcount_ff) : '0;

   kcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   kcd_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .vertex_count      (vcount_ff),
      .req_cmd           (req_ch.cmd),
      .req_edge_from     (req_ch.edge_from),
      .req_edge_to       (req_ch.edge_to),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_has_cycle     (rsp_ch.has_cycle),
      .rsp_visited_count (rsp_ch.visited_count),
      .rsp_dropped_edge  (rsp_ch.dropped_edge)
   );

   assign eval_xfer = req_ch.valid && req_ch.ready && (req_ch.cmd == kcd_pkg::CMD_EVAL);
   assign rsp_stall = rsp_ch.valid && !rsp_ch.ready;

   // a new result never overwrites one still waiting
`KCD_ASSERT_IMP(a_result_free, ctl.result_ld, !rsp_stall, "result overwritten")
   // an evaluate transfer keeps the input closed while the walk runs
`KCD_ASSERT_NXT(a_eval_busy, eval_xfer, !req_ch.ready, "input open during evaluation")
   // the queue is only popped when it holds a vertex
`KCD_ASSERT_IMP(a_pop_nonempty, ctl.pop, !sts.q_empty, "pop from empty queue")

endmodule
